[sv/eaq_pkg.sv]
`timescale 1ns / 1ps

package eaq_pkg;

    // fixed field widths
    localparam int ANGLE_W = 17;
    localparam int QUAT_W  = 16;
    // width of cordic datapath and sine / cosine values (q2.30 plus guard)
    localparam int TRIG_W  = 34;

    localparam logic [24:0] DEG_TO_RAD_Q30  = 25'd18740330;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;

    // atan(2^-i) in q2.30, truncated
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

endpackage

[sv/eaq_half_trig.sv]
`timescale 1ns / 1ps

module eaq_half_trig #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int ITERATIONS      = 16
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [eaq_pkg::ANGLE_W-1:0] angle,
    output logic signed [eaq_pkg::TRIG_W-1:0]  sin_val,
    output logic signed [eaq_pkg::TRIG_W-1:0]  cos_val
);

    localparam int W    = eaq_pkg::TRIG_W;
    localparam int HB   = ANGLE_FRAC_BITS + 1;
    localparam int D180 = 180 << HB;
    localparam int D90  = 90 << HB;
    localparam int K0   = 65536 / D180 + 1;
    localparam int OFF  = D90 + K0 * D180;
    // offset angle t' = angle + 90 + K0*180 is positive and below this bound
    localparam int TW   = $clog2(131072 + 2 * D180);
    localparam int LD   = $clog2(D180);
    localparam int SH   = TW + LD;
    localparam longint unsigned MULV = ((64'd1 << SH) + 64'(D180) - 64'd1) / 64'(D180);
    localparam int MW   = TW + 2;
    localparam int QW   = $clog2(K0 + 3);
    localparam int RW   = $clog2(D90) + 2;
    localparam int PW   = RW + 26;

    // stage 1: offset so the quotient is non-negative
    logic signed [TW:0]   ang_ext;
    logic [TW-1:0]        toff_reg;
    // stage 2: quotient by reciprocal multiply
    logic [2*TW+1:0]      qprod;
    logic [QW-1:0]        q_reg;
    logic [TW-1:0]        toff2_reg;
    // stage 3: reduced half angle
    logic signed [TW+1:0] r_full;
    logic signed [RW-1:0] r_reg;
    logic                 par3_reg;
    // stage 4: scale to radians
    logic signed [PW-1:0] prod_reg;
    logic                 par4_reg;
    // stage 5: round half away from zero
    logic [PW-1:0]        mag;
    logic [PW-1:0]        mag_rnd;
    logic signed [W-1:0]  rad_next;
    // cordic
    logic signed [W-1:0]  cx_reg [1:ITERATIONS];
    logic signed [W-1:0]  cy_reg [1:ITERATIONS];
    logic signed [W-1:0]  cz_reg [0:ITERATIONS];
    logic                 par_reg [0:ITERATIONS];
    logic signed [W-1:0]  sin_reg;
    logic signed [W-1:0]  cos_reg;

    assign ang_ext = (TW+1)'(angle);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            toff_reg <= TW'(ang_ext + (TW+1)'(OFF));
        end
    end

    assign qprod = (2*TW+2)'(toff_reg) * (2*TW+2)'(MW'(MULV));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg     <= qprod[SH +: QW];
            toff2_reg <= toff_reg;
        end
    end

    // r = angle - k*180 with k = q - K0
    assign r_full = signed'((TW+2)'(toff2_reg)) - (TW+2)'(D90)
                    - signed'((TW+2)'(q_reg) * (TW+2)'(D180));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= RW'(r_full);
            par3_reg <= q_reg[0] ^ K0[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PW'(r_reg) * signed'(PW'(eaq_pkg::DEG_TO_RAD_Q30));
            par4_reg <= par3_reg;
        end
    end

    assign mag     = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign mag_rnd = (mag + (PW'(1) << (HB - 1))) >> HB;
    assign rad_next = prod_reg[PW-1] ? -signed'(W'(mag_rnd)) : signed'(W'(mag_rnd));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cz_reg[0]  <= rad_next;
            par_reg[0] <= par4_reg;
        end
    end

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_step
        logic signed [W-1:0] xi;
        logic signed [W-1:0] yi;
        logic signed [W-1:0] at;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;

        if (i == 0)
        begin : g_first
            assign xi = signed'(W'(eaq_pkg::CORDIC_GAIN_Q30));
            assign yi = '0;
        end
        else
        begin : g_rest
            assign xi = cx_reg[i];
            assign yi = cy_reg[i];
        end

        assign at = signed'(W'(eaq_pkg::ATAN_Q30[i]));
        assign dx = yi >>> i;
        assign dy = xi >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cz_reg[i][W-1])
                begin
                    cx_reg[i+1] <= xi - dx;
                    cy_reg[i+1] <= yi + dy;
                    cz_reg[i+1] <= cz_reg[i] - at;
                end
                else
                begin
                    cx_reg[i+1] <= xi + dx;
                    cy_reg[i+1] <= yi - dy;
                    cz_reg[i+1] <= cz_reg[i] + at;
                end
                par_reg[i+1] <= par_reg[i];
            end
        end
    end

    // odd multiple of 180 degrees removed: flip both
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= par_reg[ITERATIONS] ? -cy_reg[ITERATIONS] : cy_reg[ITERATIONS];
            cos_reg <= par_reg[ITERATIONS] ? -cx_reg[ITERATIONS] : cx_reg[ITERATIONS];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

[sv/euler_angles_to_quaternion.sv]
`timescale 1ns / 1ps
// zyx euler angles to unit quaternion
// input channel s_*: one transfer carries yaw, pitch and roll in degrees,
// signed fixed point with ANGLE_FRAC_BITS fraction bits
// output channel m_*: one transfer carries quaternion w, x, y, z in signed
// fixed point with QUAT_FRAC_BITS fraction bits, saturated to plus or minus one
// every input transfer gives exactly one output transfer, in order
// pipeline from input transfer to m_tvalid:
//   5 stages of angle reduction and radian scaling, one per cordic step,
//   one sign fix, two product stages and one sum / round / saturate stage
// throughput: one transfer per cycle while the output is not stalled; the cordic
// is unrolled, one step per stage, and the three angles run in parallel lanes
// stall: while m_tvalid is high and m_tready low the whole pipeline holds,
// s_tready drops, nothing is lost or repeated
// reset: all valid bits clear, pipeline empty, s_tready high
module euler_angles_to_quaternion #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int QUAT_FRAC_BITS  = 14,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // yaw_angle[16:0], pitch_angle[33:17], roll_angle[50:34], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
);

    localparam int AW   = eaq_pkg::ANGLE_W;
    localparam int OW   = eaq_pkg::QUAT_W;
    localparam int W    = eaq_pkg::TRIG_W;
    localparam int NIT  = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
    localparam int LAT  = NIT + 9;
    localparam int PW   = 2 * W;       // q4.60 product width
    localparam int SW   = PW + 1;      // sum width
    localparam int SO   = 60 - QUAT_FRAC_BITS;
    localparam int VW   = SW - SO;

    // whole pipeline advances when the output slot is free or being taken
    logic en;
    logic vld_reg [0:LAT-1];

    logic signed [W-1:0] sy, cy, sp, cp, sr, cr;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // three angle lanes
    eaq_half_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .ITERATIONS(NIT)) u_yaw (
        .clk(clk), .en(en), .angle(signed'(s_tdata[AW-1:0])),
        .sin_val(sy), .cos_val(cy)
    );
    eaq_half_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .ITERATIONS(NIT)) u_pitch (
        .clk(clk), .en(en), .angle(signed'(s_tdata[2*AW-1:AW])),
        .sin_val(sp), .cos_val(cp)
    );
    eaq_half_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .ITERATIONS(NIT)) u_roll (
        .clk(clk), .en(en), .angle(signed'(s_tdata[3*AW-1:2*AW])),
        .sin_val(sr), .cos_val(cr)
    );

    // first products, floored back to q2.30
    logic signed [PW-1:0] p_crcp, p_srsp, p_srcp, p_crsp;
    logic signed [W-1:0]  crcp_reg, srsp_reg, srcp_reg, crsp_reg;
    logic signed [W-1:0]  sy1_reg, cy1_reg;

    assign p_crcp = PW'(cr) * PW'(cp);
    assign p_srsp = PW'(sr) * PW'(sp);
    assign p_srcp = PW'(sr) * PW'(cp);
    assign p_crsp = PW'(cr) * PW'(sp);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crcp_reg <= p_crcp[30 +: W];
            srsp_reg <= p_srsp[30 +: W];
            srcp_reg <= p_srcp[30 +: W];
            crsp_reg <= p_crsp[30 +: W];
            sy1_reg  <= sy;
            cy1_reg  <= cy;
        end
    end

    // second products, kept in q4.60
    logic signed [PW-1:0] t_w0_reg, t_w1_reg, t_x0_reg, t_x1_reg;
    logic signed [PW-1:0] t_y0_reg, t_y1_reg, t_z0_reg, t_z1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_w0_reg <= PW'(crcp_reg) * PW'(cy1_reg);
            t_w1_reg <= PW'(srsp_reg) * PW'(sy1_reg);
            t_x0_reg <= PW'(srcp_reg) * PW'(cy1_reg);
            t_x1_reg <= PW'(crsp_reg) * PW'(sy1_reg);
            t_y0_reg <= PW'(crsp_reg) * PW'(cy1_reg);
            t_y1_reg <= PW'(srcp_reg) * PW'(sy1_reg);
            t_z0_reg <= PW'(crcp_reg) * PW'(sy1_reg);
            t_z1_reg <= PW'(srsp_reg) * PW'(cy1_reg);
        end
    end

    // sum, round half up, saturate to plus or minus one
    function automatic logic [OW-1:0] to_out(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] sr_v;
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] one;
        logic signed [VW-1:0] res;
        sr_v = s + (SW'(1) <<< (SO - 1));
        v    = VW'(sr_v >>> SO);
        one  = VW'(1) <<< QUAT_FRAC_BITS;
        if (v > one)
        begin
            res = one;
        end
        else if (v < -one)
        begin
            res = -one;
        end
        else
        begin
            res = v;
        end
        return res[OW-1:0];
    endfunction

    logic [OW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qw_reg <= to_out(SW'(t_w0_reg) + SW'(t_w1_reg));
            qx_reg <= to_out(SW'(t_x0_reg) - SW'(t_x1_reg));
            qy_reg <= to_out(SW'(t_y0_reg) + SW'(t_y1_reg));
            qz_reg <= to_out(SW'(t_z0_reg) - SW'(t_z1_reg));
        end
    end

    assign m_tdata = {qz_reg, qy_reg, qx_reg, qw_reg};

endmodule

[sv/eaq_checker.sv]
`timescale 1ns / 1ps

module eaq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // input side only stalls when a result is waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output slot");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

    // the input side stalls only while the output is stalled
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

endmodule

bind euler_angles_to_quaternion eaq_checker u_eaq_checker (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
